// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and index helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_ORDER = 10;
  localparam int NUNITS    = 1 << MAX_ORDER;
  localparam int ORD_W     = $clog2(MAX_ORDER + 2);
  localparam int OFF_W     = MAX_ORDER;
  localparam int IDX_W     = MAX_ORDER + 1;
  localparam int BIT_W     = 5;
  localparam int ROW_W     = 1 << BIT_W;
  localparam int ROW_AW    = IDX_W - BIT_W;
  localparam int ROWS      = 1 << ROW_AW;
  localparam int SIZE_W    = 40;
  localparam int SH_W      = 6;
  localparam int CFG_W     = 32;
  localparam int CIDX_W    = 2;

  localparam logic [CIDX_W-1:0] REG_UNIT_SHIFT  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_BASE_OFFSET = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TOP_ORDER   = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ROW_AW-1:0] addr;
    logic [ROW_W-1:0]  wdata;
  } map_req_t;

  typedef struct packed {
    logic             valid;
    logic             fail;
    logic             alloc;
    logic [OFF_W-1:0] at;
    logic [ORD_W-1:0] ord;
  } ctl_res_t;

  // flat index of block (k, off): orders stacked from order 0 upward
  function automatic logic [IDX_W-1:0] map_index(input logic [ORD_W-1:0] k,
                                                 input logic [OFF_W-1:0] off);
    logic [IDX_W:0] tot;
    tot = (IDX_W+1)'(2 * NUNITS);
    return IDX_W'(tot - (tot >> k)) + IDX_W'(off >> k);
  endfunction

  function automatic logic [IDX_W-1:0] order_last(input logic [ORD_W-1:0] k);
    logic [IDX_W:0] tot;
    tot = (IDX_W+1)'(2 * NUNITS);
    return IDX_W'(tot - (tot >> (k + ORD_W'(1))) - (IDX_W+1)'(1));
  endfunction

endpackage

// ===== design/bba_map.sv =====
// ----------------------------------------------------------------------------
// bba_map
// Free-map storage: rows of block flags, one port, registered read data.
// ----------------------------------------------------------------------------
module bba_map import bba_pkg::*; (
  input  logic             clk,
  input  map_req_t         req,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== design/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: order search, lowest-free scan, split and merge walks.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              start,
  input  logic              req_type,
  input  logic [23:0]       num_elements,
  input  logic [15:0]       element_size,
  input  logic [OFF_W-1:0]  free_unit_offset,
  input  logic [3:0]        free_order,
  input  logic [4:0]        unit_shift,
  input  logic [ORD_W-1:0]  top,
  output logic              busy,
  output map_req_t          mreq,
  input  logic [ROW_W-1:0]  rdata,
  output ctl_res_t          res
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ORD      = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_SPLIT_RD = 4'd5;
  localparam logic [3:0] S_SPLIT_WR = 4'd6;
  localparam logic [3:0] S_FCHK     = 4'd7;
  localparam logic [3:0] S_FREE_RD  = 4'd8;
  localparam logic [3:0] S_FREE_CHK = 4'd9;
  localparam logic [3:0] S_FIN_RD   = 4'd10;
  localparam logic [3:0] S_FIN_WR   = 4'd11;

  logic [3:0]        state;
  logic [ROW_AW-1:0] crow;
  logic [ROW_AW-1:0] row;
  logic [SIZE_W-1:0] prod;
  logic [ORD_W-1:0]  ord;
  logic [ORD_W-1:0]  j;
  logic [ORD_W-1:0]  k;
  logic [OFF_W-1:0]  at;
  logic [OFF_W-1:0]  off;
  logic [3:0]        fk;

  logic [SH_W-1:0]   shamt;
  logic              fits;
  logic [IDX_W-1:0]  sj;
  logic [IDX_W-1:0]  ej;
  logic [IDX_W-1:0]  ti;
  logic [ROW_W-1:0]  masked;
  logic [BIT_W-1:0]  lo;
  logic [IDX_W-1:0]  fidx;
  logic [OFF_W-1:0]  fat;
  logic [ORD_W-1:0]  tk;
  logic [OFF_W-1:0]  toff;
  logic [IDX_W-1:0]  tidx;
  logic [OFF_W:0]    span;
  logic [OFF_W-1:0]  kbit;

  assign busy  = (state != S_IDLE);
  assign shamt = SH_W'(ord) + SH_W'(unit_shift);
  assign fits  = (prod == '0) || (((prod - SIZE_W'(1)) >> shamt) == '0);
  assign sj    = map_index(j, '0);
  assign ej    = order_last(j);
  assign ti    = map_index(top, '0);
  assign span  = (OFF_W+1)'(1) << top;
  assign kbit  = OFF_W'(1) << k;

  // entries of order j within the current row
  always_comb begin
    logic [IDX_W-1:0] idx;
    masked = '0;
    lo     = '0;
    for (int b = 0; b < ROW_W; b++) begin
      idx       = {row, BIT_W'(b)};
      masked[b] = rdata[b] && (idx >= sj) && (idx <= ej);
    end
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (masked[b]) begin
        lo = BIT_W'(b);
      end
    end
  end

  assign fidx = {row, lo};
  assign fat  = OFF_W'((fidx - sj) << j);

  // target block of the split / merge walk
  always_comb begin
    tk   = k;
    toff = off;
    case (state)
      S_SPLIT_RD, S_SPLIT_WR: begin
        tk   = k - ORD_W'(1);
        toff = at | (OFF_W'(1) << (k - ORD_W'(1)));
      end
      S_FREE_RD, S_FREE_CHK: begin
        toff = off ^ kbit;
      end
      default: begin
        tk   = k;
        toff = off;
      end
    endcase
  end

  assign tidx = map_index(tk, toff);

  always_comb begin
    mreq = '0;
    unique case (state)
      S_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.addr  = crow;
        mreq.wdata = (crow == ti[IDX_W-1:BIT_W]) ? (ROW_W'(1) << ti[BIT_W-1:0]) : '0;
      end
      S_SCAN_RD: begin
        mreq.re   = 1'b1;
        mreq.addr = row;
      end
      S_SCAN_CHK: begin
        mreq.we    = |masked;
        mreq.addr  = row;
        mreq.wdata = rdata & ~(ROW_W'(1) << lo);
      end
      S_SPLIT_RD, S_FREE_RD, S_FIN_RD: begin
        mreq.re   = 1'b1;
        mreq.addr = tidx[IDX_W-1:BIT_W];
      end
      S_SPLIT_WR, S_FIN_WR: begin
        mreq.we    = 1'b1;
        mreq.addr  = tidx[IDX_W-1:BIT_W];
        mreq.wdata = rdata | (ROW_W'(1) << tidx[BIT_W-1:0]);
      end
      S_FREE_CHK: begin
        mreq.we    = rdata[tidx[BIT_W-1:0]];
        mreq.addr  = tidx[IDX_W-1:BIT_W];
        mreq.wdata = rdata & ~(ROW_W'(1) << tidx[BIT_W-1:0]);
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      crow  <= '0;
      res   <= '0;
    end else begin
      if (restart) begin
        res.valid <= 1'b0;
        state     <= S_CLEAR;
        crow      <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            crow <= crow + ROW_AW'(1);
            if (crow == ROW_AW'(ROWS - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            // a result is held for the single idle cycle that follows it
            res.valid <= 1'b0;
            if (start) begin
              prod <= SIZE_W'(num_elements) * SIZE_W'(element_size);
              ord  <= '0;
              off  <= free_unit_offset;
              fk   <= free_order;
              state <= (req_type == REQ_FREE) ? S_FCHK : S_ORD;
            end
          end
          S_ORD: begin
            if (ord > top) begin
              res   <= '{valid: 1'b1, fail: 1'b1, alloc: 1'b0, at: '0, ord: '0};
              state <= S_IDLE;
            end else if (fits) begin
              j     <= ord;
              row   <= ROW_AW'(map_index(ord, '0) >> BIT_W);
              state <= S_SCAN_RD;
            end else begin
              ord <= ord + ORD_W'(1);
            end
          end
          S_SCAN_RD: begin
            state <= S_SCAN_CHK;
          end
          S_SCAN_CHK: begin
            if (|masked) begin
              at <= fat;
              k  <= j;
              if (j == ord) begin
                res   <= '{valid: 1'b1, fail: 1'b0, alloc: 1'b1, at: fat, ord: ord};
                state <= S_IDLE;
              end else begin
                state <= S_SPLIT_RD;
              end
            end else if (row != ej[IDX_W-1:BIT_W]) begin
              row   <= row + ROW_AW'(1);
              state <= S_SCAN_RD;
            end else if (j >= top) begin
              res   <= '{valid: 1'b1, fail: 1'b1, alloc: 1'b0, at: '0, ord: '0};
              state <= S_IDLE;
            end else begin
              j     <= j + ORD_W'(1);
              row   <= ROW_AW'(map_index(j + ORD_W'(1), '0) >> BIT_W);
              state <= S_SCAN_RD;
            end
          end
          S_SPLIT_RD: begin
            state <= S_SPLIT_WR;
          end
          S_SPLIT_WR: begin
            k <= k - ORD_W'(1);
            if (k - ORD_W'(1) == ord) begin
              res   <= '{valid: 1'b1, fail: 1'b0, alloc: 1'b1, at: at, ord: ord};
              state <= S_IDLE;
            end else begin
              state <= S_SPLIT_RD;
            end
          end
          S_FCHK: begin
            if ((4'(top) < fk) || ({1'b0, off} >= span)) begin
              res   <= '{valid: 1'b1, fail: 1'b1, alloc: 1'b0, at: '0, ord: '0};
              state <= S_IDLE;
            end else begin
              k     <= ORD_W'(fk);
              off   <= off & ~((OFF_W'(1) << fk) - OFF_W'(1));
              state <= (ORD_W'(fk) < top) ? S_FREE_RD : S_FIN_RD;
            end
          end
          S_FREE_RD: begin
            state <= S_FREE_CHK;
          end
          S_FREE_CHK: begin
            if (rdata[tidx[BIT_W-1:0]]) begin
              // buddy free: absorb it and climb one order
              off   <= off & ~kbit;
              k     <= k + ORD_W'(1);
              state <= (k + ORD_W'(1) < top) ? S_FREE_RD : S_FIN_RD;
            end else begin
              state <= S_FIN_RD;
            end
          end
          S_FIN_RD: begin
            state <= S_FIN_WR;
          end
          S_FIN_WR: begin
            res   <= '{valid: 1'b1, fail: 1'b0, alloc: 1'b0, at: '0, ord: '0};
            state <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/buddy_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over 1024 minimum-size units with a row-organized free map.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; each one yields one
// result, shown for a single cycle with done high, which the receiver must
// take as it comes. Busy stays high through the order search, the scan of
// free-map rows and the split levels of an allocate, and through the buddy
// checks and final write of a free; a rejected free skips these. done rises
// in the cycle after busy drops. The single-port free-map memory is read or
// written one row per cycle.
// After reset and after every write of top_order a clearing pass over all
// 64 rows runs with busy high.
module buddy_block_allocator_core import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [23:0]       num_elements,
  input  logic [15:0]       element_size,
  input  logic [9:0]        free_unit_offset,
  input  logic [3:0]        free_order,
  output logic              done,
  output logic              status,
  output logic [31:0]       byte_address,
  output logic [26:0]       padded_bytes,
  output logic [9:0]        unit_offset,
  output logic [3:0]        block_order
);

  logic [4:0]       unit_shift;
  logic [31:0]      base_offset;
  logic [3:0]       top_order;
  logic [ORD_W-1:0] top;
  logic             restart;
  logic             accept;
  map_req_t         mreq;
  logic [ROW_W-1:0] rdata;
  ctl_res_t         res;
  logic [SH_W-1:0]  psh;

  assign top     = (top_order > 4'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ORD_W'(top_order);
  assign restart = cfg_we && (cfg_index == REG_TOP_ORDER);
  assign accept  = start && !busy;
  assign psh     = SH_W'(res.ord) + SH_W'(unit_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_shift  <= 5'd8;
      base_offset <= '0;
      top_order   <= 4'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIT_SHIFT:  unit_shift  <= cfg_wdata[4:0];
        REG_BASE_OFFSET: base_offset <= cfg_wdata;
        REG_TOP_ORDER:   top_order   <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  bba_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .restart          (restart),
    .start            (accept),
    .req_type         (req_type),
    .num_elements     (num_elements),
    .element_size     (element_size),
    .free_unit_offset (free_unit_offset),
    .free_order       (free_order),
    .unit_shift       (unit_shift),
    .top              (top),
    .busy             (busy),
    .mreq             (mreq),
    .rdata            (rdata),
    .res              (res)
  );

  bba_map u_map (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  // result formatting: failures and frees carry zero fields
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
    status <= res.fail;
    if (res.alloc && !res.fail) begin
      byte_address <= base_offset + (32'(res.at) << unit_shift);
      padded_bytes <= 27'(1) << psh;
      unit_offset  <= res.at;
      block_order  <= 4'(res.ord);
    end else begin
      byte_address <= '0;
      padded_bytes <= '0;
      unit_offset  <= '0;
      block_order  <= '0;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks buddy_block_allocator_core against a behavioral model of the free
// map. Allocate/free requests go in through a queue-fed driver, results are
// compared field by field as they arrive, and the geometry registers are
// changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  typedef struct {
    logic        kind;
    logic [23:0] nelem;
    logic [15:0] esize;
    logic [9:0]  foff;
    logic [3:0]  ford;
  } alloc_req_t;

  typedef struct {
    logic        st;
    logic [31:0] addr;
    logic [26:0] pad;
    logic [9:0]  uoff;
    logic [3:0]  ord;
  } alloc_res_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              start;
  logic              busy;
  logic              req_type;
  logic [23:0]       num_elements;
  logic [15:0]       element_size;
  logic [9:0]        free_unit_offset;
  logic [3:0]        free_order;
  logic              done;
  logic              status;
  logic [31:0]       byte_address;
  logic [26:0]       padded_bytes;
  logic [9:0]        unit_offset;
  logic [3:0]        block_order;

  buddy_block_allocator_core uut (.*);

  // predictor state
  bit          blk_free [0:2*NUNITS-2];
  int unsigned m_shift, m_base, m_top;

  alloc_req_t  pending_reqs[$];
  alloc_res_t  expected_res[$];
  // live allocations, used to build well-formed frees
  logic [9:0]  live_off[$];
  logic [3:0]  live_ord[$];

  int errors, n_reqs, n_results, n_allocs_ok, n_frees, n_fails;
  int n_queued;

  function automatic int blk_idx(int k, int off);
    return (2 * NUNITS - ((2 * NUNITS) >> k)) + (off >> k);
  endfunction

  function automatic int eff_top();
    return (m_top > MAX_ORDER) ? MAX_ORDER : m_top;
  endfunction

  function automatic void reset_map();
    foreach (blk_free[i]) blk_free[i] = 0;
    blk_free[blk_idx(eff_top(), 0)] = 1;
  endfunction

  function automatic alloc_res_t serve_request(alloc_req_t r);
    alloc_res_t res;
    int top, span, ord, j, at, k, off;
    longint unsigned sz, units;
    bit found;
    top = eff_top();
    span = 1 << top;
    res = '{1'b1, '0, '0, '0, '0};
    if (r.kind == REQ_ALLOC) begin
      sz = longint'(r.nelem) * longint'(r.esize);
      units = (sz + ((64'd1 << m_shift) - 1)) >> m_shift;
      ord = 0;
      while ((64'd1 << ord) < units) ord++;
      if (ord > top) return res;
      found = 0;
      at = 0;
      for (j = ord; j <= top; j++) begin
        for (int o = 0; o < span; o += (1 << j)) begin
          if (blk_free[blk_idx(j, o)]) begin
            found = 1;
            at = o;
            break;
          end
        end
        if (found) break;
      end
      if (!found) return res;
      blk_free[blk_idx(j, at)] = 0;
      for (k = j; k > ord; k--) blk_free[blk_idx(k - 1, at + (1 << (k - 1)))] = 1;
      res.st = 0;
      res.addr = 32'(longint'(m_base) + (longint'(at) << m_shift));
      res.pad = 27'(64'd1 << (ord + m_shift));
      res.uoff = 10'(at);
      res.ord = 4'(ord);
    end else begin
      k = r.ford;
      off = r.foff;
      if (k > top || off >= span) return res;
      off = off & ~((1 << k) - 1);
      while (k < top) begin
        int buddy;
        buddy = off ^ (1 << k);
        if (!blk_free[blk_idx(k, buddy)]) break;
        blk_free[blk_idx(k, buddy)] = 0;
        if (buddy < off) off = buddy;
        k++;
      end
      blk_free[blk_idx(k, off)] = 1;
      res.st = 0;
    end
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: one request per accepted start, random gaps between them
  int gap_left;
  int n_sent;
  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
      gap_left <= 0;
      n_sent <= 0;
      req_type <= 0;
      num_elements <= '0;
      element_size <= '0;
      free_unit_offset <= '0;
      free_order <= '0;
    end else if (start) begin
      if (n_reqs == n_sent) begin
        // taken at the last rising edge
        start <= 0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: gap_left <= 0;
          4, 5, 6, 7: gap_left <= $urandom_range(1, 3);
          8: gap_left <= $urandom_range(4, 12);
          default: gap_left <= $urandom_range(20, 60);
        endcase
      end
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
    end else if (pending_reqs.size() > 0) begin
      alloc_req_t r;
      r = pending_reqs.pop_front();
      req_type <= r.kind;
      num_elements <= r.nelem;
      element_size <= r.esize;
      free_unit_offset <= r.foff;
      free_order <= r.ford;
      start <= 1;
      n_sent <= n_sent + 1;
    end
  end

  // acceptance seen at the rising edge; prediction
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      alloc_req_t r;
      alloc_res_t e;
      r.kind = req_type;
      r.nelem = num_elements;
      r.esize = element_size;
      r.foff = free_unit_offset;
      r.ford = free_order;
      e = serve_request(r);
      expected_res.push_back(e);
      if (r.kind == REQ_ALLOC && !e.st) begin
        live_off.push_back(e.uoff);
        live_ord.push_back(e.ord);
      end
      n_reqs++;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      alloc_res_t e;
      n_results++;
      if (expected_res.size() == 0) begin
        $display("%0t: result with none expected: st=%0d addr=%h", $time, status,
                 byte_address);
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (status !== e.st || byte_address !== e.addr || padded_bytes !== e.pad ||
            unit_offset !== e.uoff || block_order !== e.ord) begin
          $display("%0t: mismatch exp st=%0d addr=%h pad=%h off=%0d ord=%0d",
                   $time, e.st, e.addr, e.pad, e.uoff, e.ord);
          $display("%0t:          got st=%0d addr=%h pad=%h off=%0d ord=%0d",
                   $time, status, byte_address, padded_bytes, unit_offset, block_order);
          errors++;
        end
        if (e.st) n_fails++;
      end
    end
  end

  task automatic add_alloc(int unsigned ne, int unsigned es);
    pending_reqs.push_back('{REQ_ALLOC, 24'(ne), 16'(es), 10'($urandom), 4'($urandom)});
    n_queued++;
  endtask

  task automatic add_free(int unsigned off, int unsigned ord);
    pending_reqs.push_back('{REQ_FREE, 24'($urandom), 16'($urandom), 10'(off), 4'(ord)});
    n_queued++;
  endtask

  task automatic drain();
    wait (n_results == n_queued);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_UNIT_SHIFT: m_shift = val & 32'h1f;
      REG_BASE_OFFSET: m_base = val;
      default: begin
        m_top = val & 32'hf;
        reset_map();
        live_off.delete();
        live_ord.delete();
      end
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // free live blocks mostly, with noise; one pass of random traffic
  task automatic random_burst(int count);
    int sh;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 4 && live_off.size() > 0) begin
        int p;
        p = $urandom_range(0, live_off.size() - 1);
        add_free(live_off[p], live_ord[p]);
        live_off.delete(p);
        live_ord.delete(p);
      end else if ($urandom_range(0, 19) == 0) begin
        add_free($urandom, $urandom);
      end else begin
        case ($urandom_range(0, 5))
          0: add_alloc($urandom, $urandom);
          1: add_alloc($urandom_range(0, 3), $urandom_range(0, 3));
          default: begin
            sh = $urandom_range(0, m_shift + 4);
            add_alloc($urandom_range(0, 4), $urandom_range(0, (1 << sh) / 4 + 1));
          end
        endcase
      end
      // keep the live list in step with what is queued
      wait (n_reqs == n_queued);
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    m_shift = 8;
    m_base = 0;
    m_top = 10;
    reset_map();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zero size, unit, whole space, too large, invalid frees
    add_alloc(0, 0);
    add_alloc(1, 256);
    add_alloc(1, 257);
    add_alloc(1024, 256);
    add_alloc(24'hffffff, 16'hffff);
    add_alloc(0, 16'hffff);
    add_alloc(24'hffffff, 0);
    add_free(0, 0);
    add_free(1, 0);
    add_free(3, 1);
    add_free(0, 11);
    add_free(1023, 15);
    add_alloc(1024, 256);
    add_alloc(1, 1);
    add_free(0, 10);
    add_free(0, 10);
    add_alloc(1, 1);
    drain();

    write_reg(REG_UNIT_SHIFT, 31);
    write_reg(REG_BASE_OFFSET, 32'hffffffff);
    add_alloc(1, 1);
    add_alloc(3, 1);
    add_free(512, 9);
    add_free(1023, 10);
    drain();

    write_reg(REG_TOP_ORDER, 0);
    add_alloc(1, 1);
    add_alloc(1, 1);
    add_free(0, 0);
    add_free(1, 0);
    drain();
    write_reg(REG_TOP_ORDER, 15);
    write_reg(REG_UNIT_SHIFT, 0);
    write_reg(REG_BASE_OFFSET, 0);
    drain();

    random_burst(500);
    drain();
    write_reg(REG_UNIT_SHIFT, 16);
    write_reg(REG_BASE_OFFSET, $urandom);
    write_reg(REG_TOP_ORDER, 4);
    random_burst(400);
    drain();
    write_reg(REG_UNIT_SHIFT, 4);
    write_reg(REG_TOP_ORDER, 10);
    random_burst(500);
    drain();
    write_reg(REG_UNIT_SHIFT, $urandom_range(0, 31));
    write_reg(REG_BASE_OFFSET, 0);
    write_reg(REG_TOP_ORDER, $urandom_range(0, 15));
    random_burst(530);
    drain();

    $display("requests %0d, results %0d, failing results %0d", n_reqs, n_results,
             n_fails);
    if (errors == 0 && expected_res.size() == 0)
      $display("buddy_block_allocator_core verification clean");
    else
      $display("buddy_block_allocator_core verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("buddy_block_allocator_core verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bba_pkg.sv
design/bba_map.sv
design/bba_ctrl.sv
design/buddy_block_allocator_core.sv
bench/tb_top.sv
